FILE: src/epa_pkg.sv
`default_nettype none

package epa_pkg;

    localparam int LOG_LAT    = 37;
    localparam int SQRT_LAT   = 33;
    localparam int HORNER_LAT = 19;
    localparam int LATENCY    = LOG_LAT + SQRT_LAT + HORNER_LAT;

    localparam int NCOEF = 9;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [35:0] W_SPLIT   = 36'd5 << 32;
    localparam logic [36:0] T_LOW_OFS = 37'd5 << 31;
    localparam logic [36:0] T_HI_OFS  = 37'd3 << 32;
    localparam logic [23:0] X_MIN     = 24'h800000;
    localparam logic [23:0] X_MIN_FIX = 24'h800001;
    localparam logic [23:0] R_MAX     = 24'h7FFFFF;
    localparam logic [23:0] R_MIN     = 24'h800000;

    localparam logic signed [39:0] LOW_POLY [NCOEF] = '{
        40'(((64'd281022636 << 32) + (64'd10 ** 16) / 64'd2) / (64'd10 ** 16)),
        40'(((64'd343273939 << 32) + (64'd10 ** 15) / 64'd2) / (64'd10 ** 15)),
        -40'(((64'd35233877 << 32) + (64'd10 ** 13) / 64'd2) / (64'd10 ** 13)),
        -40'(((64'd439150654 << 32) + (64'd10 ** 14) / 64'd2) / (64'd10 ** 14)),
        40'(((64'd21858087 << 32) + (64'd10 ** 11) / 64'd2) / (64'd10 ** 11)),
        -40'(((64'd125372503 << 32) + (64'd10 ** 11) / 64'd2) / (64'd10 ** 11)),
        -40'(((64'd417768164 << 32) + (64'd10 ** 11) / 64'd2) / (64'd10 ** 11)),
        40'(((64'd246640727 << 32) + (64'd10 ** 9) / 64'd2) / (64'd10 ** 9)),
        40'(((64'd150140941 << 32) + (64'd10 ** 8) / 64'd2) / (64'd10 ** 8))
    };

    localparam logic signed [39:0] HIGH_POLY [NCOEF] = '{
        -40'(((64'd200214257 << 32) + (64'd10 ** 12) / 64'd2) / (64'd10 ** 12)),
        40'(((64'd100950558 << 32) + (64'd10 ** 12) / 64'd2) / (64'd10 ** 12)),
        40'(((64'd134934322 << 32) + (64'd10 ** 11) / 64'd2) / (64'd10 ** 11)),
        -40'(((64'd367342844 << 32) + (64'd10 ** 11) / 64'd2) / (64'd10 ** 11)),
        40'(((64'd573950773 << 32) + (64'd10 ** 11) / 64'd2) / (64'd10 ** 11)),
        -40'(((64'd76224613 << 32) + (64'd10 ** 10) / 64'd2) / (64'd10 ** 10)),
        40'(((64'd943887047 << 32) + (64'd10 ** 11) / 64'd2) / (64'd10 ** 11)),
        40'(((64'd100167406 << 32) + (64'd10 ** 8) / 64'd2) / (64'd10 ** 8)),
        40'(((64'd283297682 << 32) + (64'd10 ** 8) / 64'd2) / (64'd10 ** 8))
    };

endpackage

`default_nettype wire

FILE: src/epa_log.sv
`default_nettype none

module epa_log
    import epa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic signed [23:0] in_x,
    output logic                    out_valid,
    output logic signed [23:0]      out_x,
    output logic [35:0]             out_w
);

    logic signed [23:0] xc;
    logic [22:0]        ax;
    logic [45:0]        sq;
    logic [46:0]        u;

    assign xc = (in_x == X_MIN) ? X_MIN_FIX : in_x;
    assign ax = xc[23] ? 23'(-xc) : xc[22:0];
    assign sq = ax * ax;
    assign u  = (47'd1 << 46) - {1'b0, sq};

    logic               v0_reg;
    logic signed [23:0] x0_reg;
    logic [46:0]        u0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= xc;
        u0_reg <= u;
    end

    logic [46:0] n1_next;
    logic [4:0]  lz1_next;

    always_comb
    begin
        n1_next  = u0_reg;
        lz1_next = 5'd0;
        if (n1_next[46:31] == 16'd0)
        begin
            n1_next  = n1_next << 16;
            lz1_next = lz1_next + 5'd16;
        end
        if (n1_next[46:39] == 8'd0)
        begin
            n1_next  = n1_next << 8;
            lz1_next = lz1_next + 5'd8;
        end
        if (n1_next[46:43] == 4'd0)
        begin
            n1_next  = n1_next << 4;
            lz1_next = lz1_next + 5'd4;
        end
    end

    logic               v1_reg;
    logic signed [23:0] x1_reg;
    logic [46:0]        n1_reg;
    logic [4:0]         lz1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg  <= x0_reg;
        n1_reg  <= n1_next;
        lz1_reg <= lz1_next;
    end

    logic [46:0] n2_next;
    logic [4:0]  lz2_next;

    always_comb
    begin
        n2_next  = n1_reg;
        lz2_next = lz1_reg;
        if (n2_next[46:45] == 2'd0)
        begin
            n2_next  = n2_next << 2;
            lz2_next = lz2_next + 5'd2;
        end
        if (!n2_next[46])
        begin
            n2_next  = n2_next << 1;
            lz2_next = lz2_next + 5'd1;
        end
    end

    logic [31:0]        mant_reg [0:32];
    logic [31:0]        f_reg    [0:32];
    logic [4:0]         lz_reg   [0:32];
    logic signed [23:0] xs_reg   [0:32];
    logic               vs_reg   [0:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg[0] <= 1'b0;
        end
        else
        begin
            vs_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mant_reg[0] <= n2_next[46:15];
        f_reg[0]    <= 32'd0;
        lz_reg[0]   <= lz2_next;
        xs_reg[0]   <= x1_reg;
    end

    for (genvar i = 0; i < 32; i++)
    begin : g_square
        logic [63:0] prod;
        logic [31:0] mant_next;
        logic [31:0] f_next;

        assign prod = mant_reg[i] * mant_reg[i];

        always_comb
        begin
            f_next = f_reg[i];
            if (prod[63])
            begin
                mant_next      = prod[63:32];
                f_next[31 - i] = 1'b1;
            end
            else
            begin
                mant_next = prod[62:31];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vs_reg[i + 1] <= 1'b0;
            end
            else
            begin
                vs_reg[i + 1] <= vs_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            mant_reg[i + 1] <= mant_next;
            f_reg[i + 1]    <= f_next;
            lz_reg[i + 1]   <= lz_reg[i];
            xs_reg[i + 1]   <= xs_reg[i];
        end
    end

    logic [36:0] lq;
    assign lq = {lz_reg[32], 32'd0} - {5'd0, f_reg[32]};

    logic               vp_reg;
    logic signed [23:0] xp_reg;
    logic [63:0]        ppl_reg;
    logic [36:0]        pph_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
        end
        else
        begin
            vp_reg <= vs_reg[32];
        end
    end

    always_ff @(posedge clk)
    begin
        xp_reg  <= xs_reg[32];
        ppl_reg <= lq[31:0] * LN2_Q32;
        pph_reg <= lq[36:32] * LN2_Q32;
    end

    logic [68:0] wsum;
    assign wsum = {pph_reg, 32'd0} + {5'd0, ppl_reg} + (69'd1 << 31);

    logic               vw_reg;
    logic signed [23:0] xw_reg;
    logic [35:0]        w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg <= 1'b0;
        end
        else
        begin
            vw_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        xw_reg <= xp_reg;
        w_reg  <= wsum[67:32];
    end

    assign out_valid = vw_reg;
    assign out_x     = xw_reg;
    assign out_w     = w_reg;

endmodule

`default_nettype wire

FILE: src/epa_sqrt.sv
`default_nettype none

module epa_sqrt
    import epa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic signed [23:0] in_x,
    input  wire logic [35:0]        in_w,
    output logic                    out_valid,
    output logic signed [23:0]      out_x,
    output logic signed [34:0]      out_t,
    output logic                    out_low
);

    logic [63:0]        n_reg   [0:32];
    logic [63:0]        res_reg [0:32];
    logic [35:0]        w_reg   [0:32];
    logic signed [23:0] x_reg   [0:32];
    logic               v_reg   [0:32];

    always_comb
    begin
        n_reg[0]   = {2'd0, in_w, 26'd0};
        res_reg[0] = 64'd0;
        w_reg[0]   = in_w;
        x_reg[0]   = in_x;
        v_reg[0]   = in_valid;
    end

    for (genvar i = 0; i < 32; i++)
    begin : g_digit
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] trial;
        logic [63:0] n_next;
        logic [63:0] res_next;

        assign trial = res_reg[i] + BIT;

        always_comb
        begin
            if (n_reg[i] >= trial)
            begin
                n_next   = n_reg[i] - trial;
                res_next = (res_reg[i] >> 1) + BIT;
            end
            else
            begin
                n_next   = n_reg[i];
                res_next = res_reg[i] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i + 1] <= 1'b0;
            end
            else
            begin
                v_reg[i + 1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[i + 1]   <= n_next;
            res_reg[i + 1] <= res_next;
            w_reg[i + 1]   <= w_reg[i];
            x_reg[i + 1]   <= x_reg[i];
        end
    end

    logic        low;
    logic [36:0] t_low;
    logic [36:0] t_high;

    assign low    = w_reg[32] < W_SPLIT;
    assign t_low  = {1'b0, w_reg[32]} - T_LOW_OFS;
    assign t_high = {2'd0, res_reg[32][31:0], 3'd0} - T_HI_OFS;

    logic               vo_reg;
    logic signed [23:0] xo_reg;
    logic signed [34:0] t_reg;
    logic               low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= v_reg[32];
        end
    end

    always_ff @(posedge clk)
    begin
        xo_reg  <= x_reg[32];
        low_reg <= low;
        t_reg   <= low ? t_low[34:0] : t_high[34:0];
    end

    assign out_valid = vo_reg;
    assign out_x     = xo_reg;
    assign out_t     = t_reg;
    assign out_low   = low_reg;

endmodule

`default_nettype wire

FILE: src/epa_horner.sv
`default_nettype none

module epa_horner
    import epa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic signed [23:0] in_x,
    input  wire logic signed [34:0] in_t,
    input  wire logic               in_low,
    output logic                    out_valid,
    output logic signed [23:0]      out_result
);

    logic signed [39:0] p_reg   [0:8];
    logic signed [34:0] t_reg   [0:8];
    logic               low_reg [0:8];
    logic signed [23:0] x_reg   [0:8];
    logic               v_reg   [0:8];

    logic [53:0]        ppl_reg [1:8];
    logic [52:0]        pph_reg [1:8];
    logic               neg_reg [1:8];
    logic signed [34:0] ta_reg  [1:8];
    logic               lowa_reg[1:8];
    logic signed [23:0] xa_reg  [1:8];
    logic               va_reg  [1:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg[0]   <= in_low ? LOW_POLY[0] : HIGH_POLY[0];
        t_reg[0]   <= in_t;
        low_reg[0] <= in_low;
        x_reg[0]   <= in_x;
    end

    for (genvar i = 1; i < NCOEF; i++)
    begin : g_step
        logic [38:0] pm;
        logic [33:0] tm;
        logic [73:0] sum;
        logic [41:0] mag;
        logic [41:0] rnd;

        assign pm  = p_reg[i - 1][39] ? 39'(-p_reg[i - 1]) : p_reg[i - 1][38:0];
        assign tm  = t_reg[i - 1][34] ? 34'(-t_reg[i - 1]) : t_reg[i - 1][33:0];
        assign sum = {1'b0, pph_reg[i], 20'd0} + {20'd0, ppl_reg[i]} + (74'd1 << 31);
        assign mag = sum[73:32];
        assign rnd = neg_reg[i] ? -mag : mag;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg[i] <= 1'b0;
                v_reg[i]  <= 1'b0;
            end
            else
            begin
                va_reg[i] <= v_reg[i - 1];
                v_reg[i]  <= va_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            ppl_reg[i]  <= pm[19:0] * tm;
            pph_reg[i]  <= pm[38:20] * tm;
            neg_reg[i]  <= p_reg[i - 1][39] ^ t_reg[i - 1][34];
            ta_reg[i]   <= t_reg[i - 1];
            lowa_reg[i] <= low_reg[i - 1];
            xa_reg[i]   <= x_reg[i - 1];

            p_reg[i]    <= (lowa_reg[i] ? LOW_POLY[i] : HIGH_POLY[i]) + 40'(rnd);
            t_reg[i]    <= ta_reg[i];
            low_reg[i]  <= lowa_reg[i];
            x_reg[i]    <= xa_reg[i];
        end
    end

    logic [38:0] fpm;
    logic [22:0] fxm;

    assign fpm = p_reg[8][39] ? 39'(-p_reg[8]) : p_reg[8][38:0];
    assign fxm = x_reg[8][23] ? 23'(-x_reg[8]) : x_reg[8][22:0];

    logic        vf_reg;
    logic [42:0] fppl_reg;
    logic [41:0] fpph_reg;
    logic        fneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
        end
        else
        begin
            vf_reg <= v_reg[8];
        end
    end

    always_ff @(posedge clk)
    begin
        fppl_reg <= fpm[19:0] * fxm;
        fpph_reg <= fpm[38:20] * fxm;
        fneg_reg <= p_reg[8][39] ^ x_reg[8][23];
    end

    logic [62:0] fsum;
    logic [27:0] fmag;
    logic [23:0] result_next;

    assign fsum = {1'b0, fpph_reg, 20'd0} + {20'd0, fppl_reg} + (63'd1 << 34);
    assign fmag = fsum[62:35];

    always_comb
    begin
        if (fneg_reg)
        begin
            if (fmag > 28'd8388608)
            begin
                result_next = R_MIN;
            end
            else
            begin
                result_next = 24'(-fmag);
            end
        end
        else
        begin
            if (fmag > 28'd8388607)
            begin
                result_next = R_MAX;
            end
            else
            begin
                result_next = fmag[23:0];
            end
        end
    end

    logic               vo_reg;
    logic signed [23:0] result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid  = vo_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

FILE: src/erfinv_polynomial_approx.sv
`default_nettype none

// Inverse error function of a Q1.23 argument, result in Q4.20.
// Raise start for one cycle with the argument on x_value; the beat is taken
// at the rising edge while busy is low. busy never rises, so a new beat may
// enter on every clock and one result leaves on every clock.
// Each result appears on inverse_erf, marked by done for one cycle, once its
// beat has passed the logarithm, the square root and the Horner stages in
// turn. Results leave in the order the beats entered. The logarithm uses
// one squaring multiplier per fraction bit of log2; the square root works
// one digit a stage; the Horner polynomial of either set and the final
// product split each multiply into two partial products over two stages.
// The result receiver cannot stall, so nothing is ever held back.
// Reset clears every valid bit at once; beats in flight are dropped and done
// stays low until new beats come through.

module erfinv_polynomial_approx
    import epa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [23:0] x_value,
    output logic                    done,
    output logic signed [23:0]      inverse_erf
);

    logic               log_valid;
    logic signed [23:0] log_x;
    logic [35:0]        log_w;

    logic               sq_valid;
    logic signed [23:0] sq_x;
    logic signed [34:0] sq_t;
    logic               sq_low;

    assign busy = 1'b0;

    epa_log u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_x      (x_value),
        .out_valid (log_valid),
        .out_x     (log_x),
        .out_w     (log_w)
    );

    epa_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (log_valid),
        .in_x      (log_x),
        .in_w      (log_w),
        .out_valid (sq_valid),
        .out_x     (sq_x),
        .out_t     (sq_t),
        .out_low   (sq_low)
    );

    epa_horner u_horner (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sq_valid),
        .in_x       (sq_x),
        .in_t       (sq_t),
        .in_low     (sq_low),
        .out_valid  (done),
        .out_result (inverse_erf)
    );

    a_latency_fwd : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("beat did not come out after the pipeline latency");

    a_latency_bwd : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result appeared without a matching input beat");

    a_zero : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(x_value, LATENCY) != 24'd0 || inverse_erf == 24'sd0))
        else $error("zero argument gave a nonzero result");

    a_sign : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(x_value[23], LATENCY) || !inverse_erf[23]))
        else $error("positive argument gave a negative result");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb
    import epa_pkg::*;
();

    localparam int CYCLE_LIMIT = 100000;
    localparam int NUM_RANDOM = 450;
    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint LN2_FIX = 64'sd2977044472;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [23:0] x_value;
    logic done;
    logic signed [23:0] inverse_erf;

    erfinv_polynomial_approx dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .x_value(x_value),
        .done(done),
        .inverse_erf(inverse_erf)
    );

    // Polynomial coefficients, highest power first, as mantissa * 10^-exponent.
    localparam longint LOW_MANT [9] = '{281022636, 343273939, -35233877, -439150654,
        21858087, -125372503, -417768164, 246640727, 150140941};
    localparam int LOW_EXP [9] = '{16, 15, 13, 14, 11, 11, 11, 9, 8};
    localparam longint HIGH_MANT [9] = '{-200214257, 100950558, 134934322, -367342844,
        573950773, -76224613, 943887047, 100167406, 283297682};
    localparam int HIGH_EXP [9] = '{12, 12, 11, 11, 11, 10, 11, 8, 8};

    function automatic longint coef_fixed(longint mant, int exp10);
        bit [63:0] div;
        bit [63:0] mag;
        bit [63:0] q;
        div = 1;
        for (int i = 0; i < exp10; i++)
        begin
            div = div * 10;
        end
        mag = (mant < 0) ? -mant : mant;
        q = ((mag << 32) + div / 2) / div;
        return (mant < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint round_mul(longint a, longint b, int sh);
        bit neg;
        bit [127:0] ma;
        bit [127:0] mb;
        bit [127:0] pr;
        bit [63:0] r;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? 128'(-a) : 128'(a);
        mb = (b < 0) ? 128'(-b) : 128'(b);
        ma[127:64] = '0;
        mb[127:64] = '0;
        pr = ma * mb + (128'd1 << (sh - 1));
        pr = pr >> sh;
        r = pr[63:0];
        if (r > I64_MAX)
        begin
            r = I64_MAX;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] n);
        bit [63:0] res;
        bit [63:0] bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n)
        begin
            bt = bt >> 2;
        end
        while (bt != 0)
        begin
            if (n >= res + bt)
            begin
                n = n - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic longint neg_log_q46(bit [63:0] u);
        int k;
        bit [63:0] mant;
        bit [63:0] f;
        bit [63:0] lq;
        k = 0;
        f = 0;
        while (k < 63 && (u >> (k + 1)) != 0)
        begin
            k++;
        end
        mant = (k <= 31) ? (u << (31 - k)) : (u >> (k - 31));
        for (int i = 32; i > 0; i--)
        begin
            mant = (mant * mant) >> 31;
            if (mant >= (64'd1 << 32))
            begin
                f[i - 1] = 1'b1;
                mant = mant >> 1;
            end
        end
        lq = (64'(46 - k) << 32) - f;
        return round_mul(longint'(lq), LN2_FIX, 32);
    endfunction

    function automatic logic signed [23:0] predict_erfinv(logic signed [23:0] xin);
        longint x;
        bit [63:0] ax;
        longint w;
        longint t;
        longint p;
        longint r;
        bit upper;
        x = (xin == X_MIN) ? -64'sd8388607 : longint'(xin);
        ax = (x < 0) ? -x : x;
        w = neg_log_q46((64'd1 << 46) - ax * ax);
        upper = w >= (64'sd5 <<< 32);
        if (!upper)
        begin
            t = w - (64'sd5 <<< 31);
        end
        else
        begin
            t = longint'(int_sqrt(64'(w) << 26) << 3) - (64'sd3 <<< 32);
        end
        p = upper ? coef_fixed(HIGH_MANT[0], HIGH_EXP[0]) : coef_fixed(LOW_MANT[0], LOW_EXP[0]);
        for (int i = 1; i < 9; i++)
        begin
            p = (upper ? coef_fixed(HIGH_MANT[i], HIGH_EXP[i])
                       : coef_fixed(LOW_MANT[i], LOW_EXP[i])) + round_mul(p, t, 32);
        end
        r = round_mul(p, x, 35);
        if (r > 8388607)
        begin
            r = 8388607;
        end
        if (r < -8388608)
        begin
            r = -8388608;
        end
        return r[23:0];
    endfunction

    class erfinv_scoreboard;
        logic signed [23:0] pending[$];
        logic signed [23:0] args[$];
        bit failed;

        function void note_beat(logic signed [23:0] xin);
            pending.push_back(predict_erfinv(xin));
            args.push_back(xin);
        endfunction

        function void check_result(logic signed [23:0] got);
            logic signed [23:0] want;
            logic signed [23:0] arg;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, got);
                failed = 1;
            end
            else
            begin
                want = pending.pop_front();
                arg = args.pop_front();
                if (got !== want)
                begin
                    $display("%0t: x_value %0d inverse_erf expected %0d, actual %0d",
                        $time, arg, want, got);
                    failed = 1;
                end
            end
        endfunction
    endclass

    erfinv_scoreboard sb;
    bit no_idle;
    int cycles;

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_beat(x_value);
            end
            if (done)
            begin
                sb.check_result(inverse_erf);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_beat(logic signed [23:0] xin);
        while (!no_idle && $urandom_range(99) < 8)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        x_value <= xin;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [23:0] random_arg();
        int sel;
        int m;
        sel = $urandom_range(9);
        if (sel < 4)
        begin
            m = $urandom_range(8388607);
        end
        else if (sel < 6)
        begin
            m = 8388607 - $urandom_range(40000);
        end
        else if (sel < 8)
        begin
            m = 8360330 + $urandom_range(4000) - 2000;
        end
        else
        begin
            m = $urandom_range(2000);
        end
        return ($urandom_range(1) != 0) ? -24'(m) : 24'(m);
    endfunction

    initial
    begin
        logic signed [23:0] directed [$];
        clk = 0;
        sb = new();
        cycles = 0;
        no_idle = 0;
        rst_n = 0;
        start = 0;
        x_value = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        directed = '{24'sd0, 24'sd1, -24'sd1, 24'sd8388607, -24'sd8388607, X_MIN,
            24'sd4194304, -24'sd4194304, 24'sd8360330, -24'sd8360330, 24'sd8360331,
            24'sd8360329, 24'sd8388606, -24'sd8388606, 24'sd1000, 24'sh555555,
            24'shAAAAAA, 24'sh7FF000, 24'sh000FFF, -24'sd100};
        foreach (directed[i])
        begin
            send_beat(directed[i]);
        end
        drain_results();

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            no_idle = (i >= 150 && i < 300);
            send_beat(random_arg());
        end
        drain_results();
        repeat (LATENCY + 10) @(posedge clk);

        if (!sb.failed && sb.pending.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
